### hdl/bres_pkg.sv
// Shared types, constants and register codes for the bilinear RGB resizer.
`default_nettype none

package bres_pkg;

    localparam int DEF_MAX_SRC_WIDTH  = 320;
    localparam int DEF_MAX_SRC_HEIGHT = 240;
    localparam int DEF_MAX_DST_SIDE   = 160;
    localparam int QUEUE_DEPTH        = 4;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int DST_W      = 8;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 25;
    localparam int PROD_W     = DST_W + STEP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DIV_CNT_W  = $clog2(STEP_W);

    localparam logic [COL_W-1:0] RST_SRC_WIDTH  = 9'd320;
    localparam logic [ROW_W-1:0] RST_SRC_HEIGHT = 8'd240;
    localparam logic [DST_W-1:0] RST_DST_WIDTH  = 8'd160;
    localparam logic [DST_W-1:0] RST_DST_HEIGHT = 8'd160;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        NB_TL = 2'd0,
        NB_TR = 2'd1,
        NB_BL = 2'd2,
        NB_BR = 2'd3
    } t_nbr;

    typedef struct packed {
        logic [COL_W-1:0]  src_w;
        logic [ROW_W-1:0]  src_h;
        logic [STEP_W-1:0] col_step;
        logic [STEP_W-1:0] row_step;
    } t_geom;

    typedef struct packed {
        logic              is_rd;
        logic              wr_ok;
        logic [COL_W-1:0]  col_l;
        logic [COL_W-1:0]  col_h;
        logic [FRAC_W-1:0] wx;
        logic [FRAC_W-1:0] wy;
        logic [PIX_W-1:0]  pix;
    } t_job;

endpackage

`default_nettype wire

### hdl/bres_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module bres_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/bres_cfg.sv
// Size registers and the iterative divider that derives the Q9.16 step ratios.
`default_nettype none

module bres_cfg #(
    parameter int MAX_SRC_WIDTH  = bres_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bres_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_SIDE   = bres_pkg::DEF_MAX_DST_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bres_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bres_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_hold,
    output bres_pkg::t_geom                   o_geom
);

    import bres_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(STEP_W - 1);

    logic [COL_W-1:0]     r_src_w;
    logic [ROW_W-1:0]     r_src_h;
    logic [DST_W-1:0]     r_dst_w;
    logic [DST_W-1:0]     r_dst_h;
    logic                 r_start;
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [COL_W-1:0]     eff_sw;
    logic [ROW_W-1:0]     eff_sh;
    logic [DST_W-1:0]     eff_tw;
    logic [DST_W-1:0]     eff_th;

    logic [STEP_W-1:0]    r_dd [2];
    logic [STEP_W-1:0]    r_q [2];
    logic [DST_W-1:0]     r_rem [2];
    logic [DST_W-1:0]     r_dv [2];
    logic [STEP_W-1:0]    r_col_step;
    logic [STEP_W-1:0]    r_row_step;

    logic [DST_W:0]       trial [2];
    logic [DST_W-1:0]     n_rem [2];
    logic [STEP_W-1:0]    n_q [2];
    logic                 take [2];

    always_comb begin
        eff_sw = (r_src_w == '0) ? COL_W'(1) :
                 ((32'(r_src_w) > MAX_SRC_WIDTH) ? COL_W'(MAX_SRC_WIDTH) : r_src_w);
        eff_sh = (r_src_h == '0) ? ROW_W'(1) :
                 ((32'(r_src_h) > MAX_SRC_HEIGHT) ? ROW_W'(MAX_SRC_HEIGHT) : r_src_h);
        eff_tw = (r_dst_w == '0) ? DST_W'(1) :
                 ((32'(r_dst_w) > MAX_DST_SIDE) ? DST_W'(MAX_DST_SIDE) : r_dst_w);
        eff_th = (r_dst_h == '0) ? DST_W'(1) :
                 ((32'(r_dst_h) > MAX_DST_SIDE) ? DST_W'(MAX_DST_SIDE) : r_dst_h);
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            trial[k] = {r_rem[k], r_dd[k][STEP_W-1]};
            take[k]  = (trial[k] >= {1'b0, r_dv[k]});
            n_rem[k] = take[k] ? DST_W'(trial[k] - {1'b0, r_dv[k]}) : trial[k][DST_W-1:0];
            n_q[k]   = {r_q[k][STEP_W-2:0], take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
            r_start <= 1'b1;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[COL_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[ROW_W-1:0];
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data[DST_W-1:0];
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data[DST_W-1:0];
                default:        r_src_w <= r_src_w;
            endcase
            r_start <= 1'b1;
        end else if (r_start) begin
            r_start <= 1'b0;
            r_busy  <= 1'b1;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_dd[0]  <= {eff_sw, FRAC_W'(0)};
            r_dd[1]  <= {1'b0, eff_sh, FRAC_W'(0)};
            r_dv[0]  <= eff_tw;
            r_dv[1]  <= eff_th;
            r_q[0]   <= '0;
            r_q[1]   <= '0;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < 2; k++) begin
                r_dd[k]  <= {r_dd[k][STEP_W-2:0], 1'b0};
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
            if (r_cnt == DIV_LAST) begin
                r_col_step <= n_q[0];
                r_row_step <= n_q[1];
            end
        end
    end

    assign o_cfg_ready     = i_rst_n && !r_start && !r_busy;
    assign o_hold          = r_start || r_busy || i_cfg_valid;
    assign o_geom.src_w    = eff_sw;
    assign o_geom.src_h    = eff_sh;
    assign o_geom.col_step = r_col_step;
    assign o_geom.row_step = r_row_step;

endmodule

`default_nettype wire

### hdl/bres_front.sv
// Front end: accepts items, scales read coordinates and forms store row bases.
`default_nettype none

module bres_front #(
    parameter int MAX_SRC_WIDTH  = bres_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bres_pkg::DEF_MAX_SRC_HEIGHT,
    localparam int ADDR_W = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  bres_pkg::t_geom               i_geom,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [bres_pkg::COL_W-1:0]    i_src_col,
    input  logic [bres_pkg::ROW_W-1:0]    i_src_row,
    input  logic [bres_pkg::PIX_W-1:0]    i_pix,
    input  logic [bres_pkg::DST_W-1:0]    i_dst_col,
    input  logic [bres_pkg::DST_W-1:0]    i_dst_row,
    input  logic                          i_q_full,
    output logic                          o_push,
    output bres_pkg::t_job                o_job,
    output logic [ADDR_W-1:0]             o_base_l,
    output logic [ADDR_W-1:0]             o_base_h
);

    import bres_pkg::*;

    localparam int XI_W = PROD_W - FRAC_W;

    logic              r_f1_valid;
    logic              r_f1_rd;
    logic              r_f1_wr_ok;
    logic [COL_W-1:0]  r_f1_col;
    logic [ROW_W-1:0]  r_f1_row;
    logic [PIX_W-1:0]  r_f1_pix;
    logic [PROD_W-1:0] r_f1_x;
    logic [PROD_W-1:0] r_f1_y;

    logic              r_f2_valid;
    t_job              r_f2_job;
    logic [ADDR_W-1:0] r_f2_base_l;
    logic [ADDR_W-1:0] r_f2_base_h;

    logic              f1_take;
    logic              f2_take;
    logic              accept;

    logic [XI_W-1:0]   xl_raw;
    logic [XI_W-1:0]   yl_raw;
    logic [COL_W-1:0]  sw_last;
    logic [ROW_W-1:0]  sh_last;
    logic [COL_W-1:0]  xl;
    logic [COL_W-1:0]  xh;
    logic [ROW_W-1:0]  yl;
    logic [ROW_W-1:0]  yh;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [ADDR_W-1:0] base_l;
    logic [ADDR_W-1:0] base_h;
    t_job              job;

    assign f2_take    = !r_f2_valid || !i_q_full;
    assign f1_take    = !r_f1_valid || f2_take;
    assign o_in_stall = !i_rst_n || i_hold || !f1_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        xl_raw  = r_f1_x[PROD_W-1:FRAC_W];
        yl_raw  = r_f1_y[PROD_W-1:FRAC_W];
        sw_last = i_geom.src_w - COL_W'(1);
        sh_last = i_geom.src_h - ROW_W'(1);
        xl      = (xl_raw > XI_W'(sw_last)) ? sw_last : xl_raw[COL_W-1:0];
        yl      = (yl_raw > XI_W'(sh_last)) ? sh_last : yl_raw[ROW_W-1:0];
        xh      = ((COL_W+1)'(xl) + 1'b1 < (COL_W+1)'(i_geom.src_w)) ? xl + 1'b1 : xl;
        yh      = ((ROW_W+1)'(yl) + 1'b1 < (ROW_W+1)'(i_geom.src_h)) ? yl + 1'b1 : yl;
        row_sel = r_f1_rd ? yl : r_f1_row;
        col_sel = r_f1_rd ? xl : r_f1_col;
        base_l  = ADDR_W'(row_sel) * ADDR_W'(MAX_SRC_WIDTH);
        base_h  = (r_f1_rd && (yh != yl)) ? base_l + ADDR_W'(MAX_SRC_WIDTH) : base_l;

        job.is_rd = r_f1_rd;
        job.wr_ok = r_f1_wr_ok;
        job.col_l = col_sel;
        job.col_h = xh;
        job.wx    = r_f1_x[FRAC_W-1:0];
        job.wy    = r_f1_y[FRAC_W-1:0];
        job.pix   = r_f1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (f1_take) begin
                r_f1_valid <= accept;
            end
            if (f2_take) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_take) begin
            r_f1_rd    <= (t_cmd'(i_cmd) == CMD_READ);
            r_f1_wr_ok <= (32'(i_src_col) < MAX_SRC_WIDTH) && (32'(i_src_row) < MAX_SRC_HEIGHT);
            r_f1_col   <= i_src_col;
            r_f1_row   <= i_src_row;
            r_f1_pix   <= i_pix;
            r_f1_x     <= PROD_W'(i_dst_col) * PROD_W'(i_geom.col_step);
            r_f1_y     <= PROD_W'(i_dst_row) * PROD_W'(i_geom.row_step);
        end
        if (f2_take) begin
            r_f2_job    <= job;
            r_f2_base_l <= base_l;
            r_f2_base_h <= base_h;
        end
    end

    assign o_push   = r_f2_valid && !i_q_full;
    assign o_job    = r_f2_job;
    assign o_base_l = r_f2_base_l;
    assign o_base_h = r_f2_base_h;

endmodule

`default_nettype wire

### hdl/bres_fifo.sv
// Short job queue between the front end and the back end.
`default_nettype none

module bres_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bres_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hdl/bres_back.sv
// Back end: frame store access, neighbor gathering and the interpolation pipeline.
`default_nettype none

module bres_back #(
    parameter int STORE_DEPTH = bres_pkg::DEF_MAX_SRC_WIDTH * bres_pkg::DEF_MAX_SRC_HEIGHT,
    localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  bres_pkg::t_job              i_job,
    input  logic [ADDR_W-1:0]           i_base_l,
    input  logic [ADDR_W-1:0]           i_base_h,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bres_pkg::CH_W-1:0]   o_out_red,
    output logic [bres_pkg::CH_W-1:0]   o_out_green,
    output logic [bres_pkg::CH_W-1:0]   o_out_blue
);

    import bres_pkg::*;

    localparam int TOP_W = CH_W + FRAC_W;
    localparam int MUL1_W = TOP_W + 2;
    localparam int MUL2_W = TOP_W + FRAC_W + 2;

    logic              r_cur_valid;
    t_job              r_cur;
    logic [ADDR_W-1:0] r_cur_base_l;
    logic [ADDR_W-1:0] r_cur_base_h;
    t_nbr              r_phase;
    t_nbr              n_phase;

    logic              r_rd_valid;
    t_nbr              r_rd_phase;
    logic [FRAC_W-1:0] r_rd_wx;
    logic [FRAC_W-1:0] r_rd_wy;
    logic [PIX_W-1:0]  r_px [3];

    logic              r_p_valid;
    logic [PIX_W-1:0]  r_p_px [4];
    logic [FRAC_W-1:0] r_p_wx;
    logic [FRAC_W-1:0] r_p_wy;

    logic              r_s1_valid;
    logic [TOP_W-1:0]  r_s1_top [NUM_CH];
    logic [TOP_W-1:0]  r_s1_bot [NUM_CH];
    logic [FRAC_W-1:0] r_s1_wy;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch [NUM_CH];

    logic              adv;
    logic              cur_last;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] sel_base;
    logic [COL_W-1:0]  sel_col;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_rdata;

    logic [CH_W-1:0]           ch_px [4];
    logic signed [CH_W:0]      diff_t;
    logic signed [CH_W:0]      diff_b;
    logic signed [MUL1_W-1:0]  sum_t;
    logic signed [MUL1_W-1:0]  sum_b;
    logic [TOP_W-1:0]          n_top [NUM_CH];
    logic [TOP_W-1:0]          n_bot [NUM_CH];
    logic signed [TOP_W:0]     diff_v;
    logic signed [MUL2_W-1:0]  sum_v;
    logic [CH_W-1:0]           n_ch [NUM_CH];

    assign adv      = !r_out_valid || !i_out_stall;
    assign cur_last = !r_cur.is_rd || (r_phase == NB_BR);
    assign o_q_pop  = adv && i_q_valid && (!r_cur_valid || cur_last);
    assign ram_we   = adv && r_cur_valid && !r_cur.is_rd && r_cur.wr_ok;
    assign ram_re   = adv && r_cur_valid && r_cur.is_rd;

    always_comb begin
        case (r_phase)
            NB_TL: begin
                sel_base = r_cur_base_l;
                sel_col  = r_cur.col_l;
                n_phase  = NB_TR;
            end
            NB_TR: begin
                sel_base = r_cur_base_l;
                sel_col  = r_cur.col_h;
                n_phase  = NB_BL;
            end
            NB_BL: begin
                sel_base = r_cur_base_h;
                sel_col  = r_cur.col_l;
                n_phase  = NB_BR;
            end
            default: begin
                sel_base = r_cur_base_h;
                sel_col  = r_cur.col_h;
                n_phase  = NB_TL;
            end
        endcase
        ram_addr = sel_base + ADDR_W'(sel_col);
    end

    bres_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_cur.pix),
        .o_rdata (ram_rdata)
    );

    // Horizontal pass on each channel, exact in Q8.16.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            for (int n = 0; n < 4; n++) begin
                ch_px[n] = r_p_px[n][PIX_W-1-CH_W*c -: CH_W];
            end
            diff_t   = $signed({1'b0, ch_px[1]}) - $signed({1'b0, ch_px[0]});
            diff_b   = $signed({1'b0, ch_px[3]}) - $signed({1'b0, ch_px[2]});
            sum_t    = $signed({2'b00, ch_px[0], FRAC_W'(0)}) + $signed({1'b0, r_p_wx}) * diff_t;
            sum_b    = $signed({2'b00, ch_px[2], FRAC_W'(0)}) + $signed({1'b0, r_p_wx}) * diff_b;
            n_top[c] = sum_t[TOP_W-1:0];
            n_bot[c] = sum_b[TOP_W-1:0];
        end
    end

    // Vertical pass in Q8.32, truncated to the integer part.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            diff_v  = $signed({1'b0, r_s1_bot[c]}) - $signed({1'b0, r_s1_top[c]});
            sum_v   = $signed({2'b00, r_s1_top[c], FRAC_W'(0)}) + $signed({1'b0, r_s1_wy}) * diff_v;
            n_ch[c] = sum_v[TOP_W+FRAC_W-1 -: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_phase     <= NB_TL;
            r_rd_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (o_q_pop) begin
                r_cur_valid <= 1'b1;
                r_phase     <= NB_TL;
            end else if (r_cur_valid && cur_last) begin
                r_cur_valid <= 1'b0;
                r_phase     <= NB_TL;
            end else if (r_cur_valid) begin
                r_phase <= n_phase;
            end
            r_rd_valid  <= ram_re;
            r_p_valid   <= r_rd_valid && (r_rd_phase == NB_BR);
            r_s1_valid  <= r_p_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_q_pop) begin
                r_cur        <= i_job;
                r_cur_base_l <= i_base_l;
                r_cur_base_h <= i_base_h;
            end
            r_rd_phase <= r_phase;
            r_rd_wx    <= r_cur.wx;
            r_rd_wy    <= r_cur.wy;
            if (r_rd_valid && (r_rd_phase != NB_BR)) begin
                r_px[2'(r_rd_phase)] <= ram_rdata;
            end
            if (r_rd_valid && (r_rd_phase == NB_BR)) begin
                r_p_px[0] <= r_px[0];
                r_p_px[1] <= r_px[1];
                r_p_px[2] <= r_px[2];
                r_p_px[3] <= ram_rdata;
                r_p_wx    <= r_rd_wx;
                r_p_wy    <= r_rd_wy;
            end
            r_s1_top <= n_top;
            r_s1_bot <= n_bot;
            r_s1_wy  <= r_p_wy;
            r_out_ch <= n_ch;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_blue  = r_out_ch[2];

endmodule

`default_nettype wire

### hdl/bilinear_rgb_resizer.sv
// Bilinear RGB888 resizer: a write item stores one source pixel, a read item returns one.
// Throughput: one write item per cycle unless stalled; a read item makes the four neighbor
// reads through the single port of the frame store before the next item is taken.
// Reset is synchronous and active low; the step ratios are then recomputed with input
// stalled, as after every size register write. The frame store is not cleared.
`default_nettype none

module bilinear_rgb_resizer #(
    parameter int MAX_SRC_WIDTH  = bres_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bres_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_SIDE   = bres_pkg::DEF_MAX_DST_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bres_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bres_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [bres_pkg::COL_W-1:0]      i_src_col,
    input  logic [bres_pkg::ROW_W-1:0]      i_src_row,
    input  logic [bres_pkg::CH_W-1:0]       i_in_red,
    input  logic [bres_pkg::CH_W-1:0]       i_in_green,
    input  logic [bres_pkg::CH_W-1:0]       i_in_blue,
    input  logic [bres_pkg::DST_W-1:0]      i_dst_col,
    input  logic [bres_pkg::DST_W-1:0]      i_dst_row,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bres_pkg::CH_W-1:0]       o_out_red,
    output logic [bres_pkg::CH_W-1:0]       o_out_green,
    output logic [bres_pkg::CH_W-1:0]       o_out_blue
);

    import bres_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int Q_W         = $bits(t_job) + 2 * ADDR_W;

    t_geom             geom;
    logic              hold;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    t_job              f_job;
    logic [ADDR_W-1:0] f_base_l;
    logic [ADDR_W-1:0] f_base_h;
    t_job              b_job;
    logic [ADDR_W-1:0] b_base_l;
    logic [ADDR_W-1:0] b_base_h;
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    q_out;

    bres_cfg #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_SIDE   (MAX_DST_SIDE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_hold      (hold),
        .o_geom      (geom)
    );

    bres_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (hold),
        .i_geom     (geom),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_src_col  (i_src_col),
        .i_src_row  (i_src_row),
        .i_pix      ({i_in_red, i_in_green, i_in_blue}),
        .i_dst_col  (i_dst_col),
        .i_dst_row  (i_dst_row),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (f_job),
        .o_base_l   (f_base_l),
        .o_base_h   (f_base_h)
    );

    assign q_in = {f_job, f_base_l, f_base_h};
    assign {b_job, b_base_l, b_base_h} = q_out;

    bres_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    bres_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (b_job),
        .i_base_l    (b_base_l),
        .i_base_h    (b_base_h),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

endmodule

`default_nettype wire

### hdl/bres_chk.sv
// Port-level checker for the resizer and the bind that attaches it.
`default_nettype none

module bres_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [bres_pkg::CH_W-1:0] o_out_red,
    input logic [bres_pkg::CH_W-1:0] o_out_green,
    input logic [bres_pkg::CH_W-1:0] o_out_blue
);

    // The ratio computation must keep the item channel closed.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_in_stall)
        else $error("item accepted while step ratios are being computed");

    // A register write restarts the ratio computation in the next cycle.
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (!o_cfg_ready && o_in_stall))
        else $error("register write did not hold off items and writes");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue)))
        else $error("stalled result changed or was dropped");

endmodule

bind bilinear_rgb_resizer bres_chk u_bres_chk (.*);

`default_nettype wire
